### hw/rtl/flvf_pkg.sv
// Shared types and constants for the FLV tag framer.
package flvf_pkg;

    localparam int unsigned IDX_W   = 25;
    localparam int unsigned LEN_W   = 25;
    localparam int unsigned STAMP_W = 24;

    localparam logic [23:0]      FLV_MAGIC    = 24'h464C56;
    localparam logic [LEN_W-1:0] HEADER_LEN   = 25'd13;
    localparam logic [LEN_W-1:0] TAG_OVERHEAD = 25'd15;
    localparam logic [32:0]      TAIL_ADD     = 33'd4;
    localparam logic [7:0]       VIDEO_TYPE   = 8'd9;

    // Byte positions inside a tag that carry fields of interest.
    localparam logic [IDX_W-1:0] POS_KIND      = 25'd0;
    localparam logic [IDX_W-1:0] POS_MAGIC_END = 25'd2;
    localparam logic [IDX_W-1:0] POS_SIZE_END  = 25'd3;
    localparam logic [IDX_W-1:0] POS_STAMP_LO  = 25'd4;
    localparam logic [IDX_W-1:0] POS_STAMP_HI  = 25'd6;
    localparam logic [IDX_W-1:0] POS_VIDEO     = 25'd11;
    localparam logic [IDX_W-1:0] POS_MIN_END   = 25'd12;

    typedef struct packed {
        logic               is_file_header;
        logic [7:0]         tag_type;
        logic [LEN_W-1:0]   packet_length;
        logic [STAMP_W-1:0] time_stamp;
        logic               is_video;
        logic [3:0]         codec_id;
        logic [3:0]         frame_kind;
        logic               length_ok;
    } result_t;

    typedef struct packed {
        logic fin;       // the byte being processed ends a packet
    } parse_status_t;

endpackage

### hw/rtl/flv_tag_framer.sv
// Top level of the FLV tag framer: input word register, parser and result register.
//
// The block frames a raw FLV byte stream into packets. Each input word on the
// s_ channel carries one byte of the stream. A packet that opens with the bytes
// 'F','L','V' is the 13-byte file header; any other packet is a tag whose total
// length is its 24-bit data size plus 15. When the last byte of a packet has
// been processed, one result word appears on the m_ channel with the kind,
// tag type, length, timestamp, video codec and frame nibbles, and a flag that
// tells whether the trailing previous-tag-size plus 4 matched the length. On a
// mismatch the flag is low and framing resumes right after the claimed length.
// Bytes that do not end a packet produce no result word.
// Throughput is one byte per clock cycle while s_ready is high. An accepted
// byte is held in the input register and is then parsed into the result
// register, so m_valid rises once the last byte of a packet has reached it.
// While the receiver stalls, the pending result holds and bytes that do not
// end a packet keep flowing; s_ready only drops when the byte in the input
// register ends a packet and the result register is still full.
// A synchronous low on aresetn empties both registers and restarts framing at
// the beginning of a packet.
module flv_tag_framer (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic [7:0]                          s_data_byte,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_is_file_header,
    output logic [7:0]                          m_tag_type,
    output logic [flvf_pkg::LEN_W-1:0]          m_packet_length,
    output logic [flvf_pkg::STAMP_W-1:0]        m_time_stamp,
    output logic                                m_is_video,
    output logic [3:0]                          m_codec_id,
    output logic [3:0]                          m_frame_kind,
    output logic                                m_length_ok
);

    logic                    in_valid_reg;
    logic [7:0]              in_byte_reg;
    logic                    out_valid_reg;
    flvf_pkg::result_t       out_reg;
    flvf_pkg::result_t       parse_result;
    flvf_pkg::parse_status_t parse_status;
    logic                    advance;
    logic                    out_free;
    logic                    s_accept;

    // The result register is free when empty or being emptied this cycle.
    assign out_free = !out_valid_reg || m_ready;
    // A buffered byte moves on unless it ends a packet with nowhere to go.
    assign advance  = in_valid_reg && (!parse_status.fin || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign s_accept = s_valid && s_ready;

    flvf_parse u_parse (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (advance),
        .data_byte (in_byte_reg),
        .status    (parse_status),
        .result    (parse_result)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_data_byte;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && parse_status.fin) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && parse_status.fin) begin
            out_reg <= parse_result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_is_file_header = out_reg.is_file_header;
    assign m_tag_type       = out_reg.tag_type;
    assign m_packet_length  = out_reg.packet_length;
    assign m_time_stamp     = out_reg.time_stamp;
    assign m_is_video       = out_reg.is_video;
    assign m_codec_id       = out_reg.codec_id;
    assign m_frame_kind     = out_reg.frame_kind;
    assign m_length_ok      = out_reg.length_ok;

    // A packet end that is processed always lands in the result register.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && parse_status.fin) |=> out_valid_reg)
        else $error("finished packet did not produce a result word");

    // Backpressure reaches the input only when both registers are occupied.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && out_valid_reg && !m_ready))
        else $error("input stalled without a full pipeline");

    // A byte held in the input register keeps its value until it moves on.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !advance) |=> (in_valid_reg && $stable(in_byte_reg)))
        else $error("buffered byte lost while stalled");

    // The file header result always reports 13 bytes and a good length.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_reg.is_file_header) |->
            (out_reg.packet_length == flvf_pkg::HEADER_LEN && out_reg.length_ok))
        else $error("file header result is malformed");

endmodule

### hw/rtl/flvf_parse.sv
// Packet parsing state and per-byte result logic of the FLV tag framer.
module flvf_parse (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    step,
    input  logic [7:0]              data_byte,
    output flvf_pkg::parse_status_t status,
    output flvf_pkg::result_t       result
);

    logic [flvf_pkg::IDX_W-1:0]   idx_reg, idx_next;
    logic [23:0]                  head_reg, head_next;
    logic                         hdr_reg, hdr_next;
    logic [7:0]                   kind_reg, kind_next;
    logic [flvf_pkg::LEN_W-1:0]   length_reg, length_next;
    logic [flvf_pkg::STAMP_W-1:0] stamp_reg, stamp_next;
    logic [7:0]                   video_reg, video_next;
    logic [31:0]                  tail_reg, tail_next;
    logic                         fin;
    logic                         vid;

    always_comb begin
        head_next   = head_reg;
        hdr_next    = hdr_reg;
        kind_next   = kind_reg;
        length_next = length_reg;
        stamp_next  = stamp_reg;
        video_next  = video_reg;
        tail_next   = {tail_reg[23:0], data_byte};

        if (idx_reg < 25'd3) begin
            head_next = {head_reg[15:0], data_byte};
        end
        if (idx_reg == flvf_pkg::POS_KIND) begin
            kind_next = data_byte;
        end
        if (idx_reg == flvf_pkg::POS_MAGIC_END) begin
            hdr_next = (head_next == flvf_pkg::FLV_MAGIC);
            if (hdr_next) begin
                length_next = flvf_pkg::HEADER_LEN;
            end
        end
        // The data size is complete at the fourth byte of a tag.
        if (idx_reg == flvf_pkg::POS_SIZE_END && !hdr_reg) begin
            length_next = {1'b0, head_reg[15:0], data_byte} + flvf_pkg::TAG_OVERHEAD;
        end
        if (idx_reg inside {[flvf_pkg::POS_STAMP_LO:flvf_pkg::POS_STAMP_HI]}) begin
            stamp_next = {stamp_reg[15:0], data_byte};
        end
        if (idx_reg == flvf_pkg::POS_VIDEO) begin
            video_next = data_byte;
        end
    end

    // Every packet is at least 13 bytes long, so the length and all header
    // fields are settled by the time the end test can fire.
    assign fin = (idx_reg >= flvf_pkg::POS_MIN_END) &&
                 (({1'b0, idx_reg} + 26'd1) == {1'b0, length_reg});
    assign idx_next = fin ? '0 : idx_reg + 25'd1;

    assign vid = !hdr_reg && (kind_reg == flvf_pkg::VIDEO_TYPE);

    always_comb begin
        result.is_file_header = hdr_reg;
        result.tag_type       = hdr_reg ? 8'd0 : kind_reg;
        result.packet_length  = length_reg;
        result.time_stamp     = hdr_reg ? '0 : stamp_reg;
        result.is_video       = vid;
        result.codec_id       = vid ? video_reg[3:0] : 4'd0;
        result.frame_kind     = vid ? video_reg[7:4] : 4'd0;
        // The trailing size is compared at full width so that it cannot wrap.
        result.length_ok      = hdr_reg ||
            (({1'b0, tail_next} + flvf_pkg::TAIL_ADD) == {8'd0, length_reg});
    end

    assign status.fin = fin;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg    <= '0;
            head_reg   <= '0;
            hdr_reg    <= 1'b0;
            kind_reg   <= '0;
            length_reg <= '0;
            stamp_reg  <= '0;
            video_reg  <= '0;
            tail_reg   <= '0;
        end else if (step) begin
            idx_reg    <= idx_next;
            head_reg   <= head_next;
            hdr_reg    <= hdr_next;
            kind_reg   <= kind_next;
            length_reg <= length_next;
            stamp_reg  <= stamp_next;
            video_reg  <= video_next;
            tail_reg   <= tail_next;
        end
    end

endmodule

### sim/tb_flv_tag_framer.sv
// Self-checking testbench for the FLV tag framer: directed packet table, random stream.
module tb_flv_tag_framer;

    // Tag types that the stream generator picks most of the time.
    typedef enum logic [7:0] {
        TAG_AUDIO  = 8'd8,
        TAG_VIDEO  = 8'd9,
        TAG_SCRIPT = 8'd18
    } tag_kind_e;

    localparam logic [23:0] FILE_MAGIC     = 24'h464C56;
    localparam int unsigned HDR_BYTES      = 13;
    localparam int unsigned TAG_EXTRA      = 15;
    localparam int unsigned BACK_ADD       = 4;
    localparam int unsigned STREAM_BYTES   = 1250;
    localparam int unsigned DRAIN_AT       = 10;
    localparam int unsigned WATCHDOG_LIMIT = 4000;

    // One packet of the stream. The bytes are built from these fields; the
    // expected result is typed in only for rows whose outcome is plain.
    typedef struct packed {
        logic               file_hdr;
        logic [7:0]         kind;
        logic [23:0]        size;
        logic [23:0]        stamp;
        logic [7:0]         flags;
        logic [31:0]        back_size;
        logic               typed;
        flvf_pkg::result_t  want;
    } pkt_row_t;

    localparam int unsigned DIR_ROWS = 9;
    localparam pkt_row_t DIR_TABLE [DIR_ROWS] = '{
        // File header right after reset.
        '{1'b1, 8'h00, 24'd0, 24'h000000, 8'h00, 32'd0, 1'b1,
          '{1'b1, 8'h00, 25'd13, 24'h000000, 1'b0, 4'h0, 4'h0, 1'b1}},
        // Empty video tag: the flags byte is the top byte of the trailing size,
        // and a trailing size of all ones must not wrap into a match.
        '{1'b0, TAG_VIDEO, 24'd0, 24'hFFFFFF, 8'h00, 32'hFFFFFFFF, 1'b1,
          '{1'b0, TAG_VIDEO, 25'd15, 24'hFFFFFF, 1'b1, 4'hF, 4'hF, 1'b0}},
        // Smallest video tag with data and a correct trailing size.
        '{1'b0, TAG_VIDEO, 24'd1, 24'h000000, 8'h17, 32'd12, 1'b1,
          '{1'b0, TAG_VIDEO, 25'd16, 24'h000000, 1'b1, 4'h7, 4'h1, 1'b1}},
        '{1'b0, TAG_AUDIO, 24'd2, 24'h123456, 8'hA5, 32'd13, 1'b1,
          '{1'b0, TAG_AUDIO, 25'd17, 24'h123456, 1'b0, 4'h0, 4'h0, 1'b1}},
        // Script tag with a zero trailing size: a size mismatch.
        '{1'b0, TAG_SCRIPT, 24'd3, 24'h0000FF, 8'h00, 32'd0, 1'b1,
          '{1'b0, TAG_SCRIPT, 25'd18, 24'h0000FF, 1'b0, 4'h0, 4'h0, 1'b0}},
        // Tag whose type byte is the first letter of the file magic.
        '{1'b0, FILE_MAGIC[23:16], 24'd4, 24'hABCDEF, 8'h2C, 32'd15, 1'b0, '0},
        // Trailing size correct in its low bits, wrong only in the top bit.
        '{1'b0, 8'hFF, 24'd0, 24'h5A5A5A, 8'h00, 32'h8000000B, 1'b0, '0},
        '{1'b0, 8'h00, 24'd0, 24'h000000, 8'h00, 32'd11, 1'b1,
          '{1'b0, 8'h00, 25'd15, 24'h000000, 1'b0, 4'h0, 4'h0, 1'b1}},
        // A second file header in the middle of the stream.
        '{1'b1, 8'h00, 24'd0, 24'h000000, 8'h00, 32'd0, 1'b1,
          '{1'b1, 8'h00, 25'd13, 24'h000000, 1'b0, 4'h0, 4'h0, 1'b1}}
    };

    logic                           aclk = 1'b0;
    logic                           aresetn = 1'b0;
    logic                           s_valid = 1'b0;
    logic                           s_ready;
    logic [7:0]                     s_data_byte = 8'h00;
    logic                           m_valid;
    logic                           m_ready = 1'b0;
    logic                           m_is_file_header;
    logic [7:0]                     m_tag_type;
    logic [flvf_pkg::LEN_W-1:0]     m_packet_length;
    logic [flvf_pkg::STAMP_W-1:0]   m_time_stamp;
    logic                           m_is_video;
    logic [3:0]                     m_codec_id;
    logic [3:0]                     m_frame_kind;
    logic                           m_length_ok;

    always #10 aclk = ~aclk;

    flv_tag_framer i_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_data_byte      (s_data_byte),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_is_file_header (m_is_file_header),
        .m_tag_type       (m_tag_type),
        .m_packet_length  (m_packet_length),
        .m_time_stamp     (m_time_stamp),
        .m_is_video       (m_is_video),
        .m_codec_id       (m_codec_id),
        .m_frame_kind     (m_frame_kind),
        .m_length_ok      (m_length_ok)
    );

    // Framing state of the predictor, kept apart from the block's own.
    logic [24:0]        pkt_pos = '0;
    logic [23:0]        lead_bytes = '0;
    logic               in_file_hdr = 1'b0;
    logic [7:0]         kind_byte = '0;
    logic [24:0]        pkt_len = '0;
    logic [23:0]        stamp_bytes = '0;
    logic [7:0]         flag_byte = '0;
    logic [31:0]        tail_bytes = '0;

    flvf_pkg::result_t  frames_due [$];
    flvf_pkg::result_t  typed_frame;
    flvf_pkg::result_t  seen_frame;
    flvf_pkg::result_t  due_frame;
    logic               use_typed = 1'b0;
    logic               tx_free = 1'b0;
    int unsigned        bad_frames = 0;
    int unsigned        quiet_cycles = 0;
    int unsigned        stall_left = 0;
    int unsigned        mode_left = 0;
    logic               rx_free = 1'b0;

    // Gap length for either side: mostly none or short, now and then long.
    function automatic int unsigned idle_len();
        int unsigned p;
        p = $urandom_range(0, 99);
        if (p < 55) begin
            return 0;
        end else if (p < 85) begin
            return $urandom_range(1, 3);
        end else if (p < 97) begin
            return $urandom_range(4, 12);
        end
        return $urandom_range(20, 60);
    endfunction

    // Advances the framing state by one stream byte. Returns 1 when the byte
    // closes a packet, with the packet's result word in frame.
    function automatic logic frame_on_byte(input logic [7:0] b,
                                           output flvf_pkg::result_t frame);
        logic closes;
        logic video;
        frame = '0;
        if (pkt_pos < 3) begin
            lead_bytes = {lead_bytes[15:0], b};
            if (pkt_pos == 0) begin
                kind_byte = b;
            end
            if (pkt_pos == 2) begin
                in_file_hdr = (lead_bytes == FILE_MAGIC);
                if (in_file_hdr) begin
                    pkt_len = 25'(HDR_BYTES);
                end
            end
        end else if (pkt_pos == 3 && !in_file_hdr) begin
            pkt_len = 25'({lead_bytes[15:0], b}) + 25'(TAG_EXTRA);
        end
        if (pkt_pos >= 4 && pkt_pos <= 6) begin
            stamp_bytes = {stamp_bytes[15:0], b};
        end
        if (pkt_pos == 11) begin
            flag_byte = b;
        end
        tail_bytes = {tail_bytes[23:0], b};

        closes = (pkt_pos >= 12) && (32'(pkt_pos) + 32'd1 == 32'(pkt_len));
        if (closes) begin
            video = !in_file_hdr && (kind_byte == TAG_VIDEO);
            frame.is_file_header = in_file_hdr;
            frame.tag_type       = in_file_hdr ? 8'h00 : kind_byte;
            frame.packet_length  = pkt_len;
            frame.time_stamp     = in_file_hdr ? 24'h000000 : stamp_bytes;
            frame.is_video       = video;
            frame.codec_id       = video ? flag_byte[3:0] : 4'h0;
            frame.frame_kind     = video ? flag_byte[7:4] : 4'h0;
            // The trailing size is compared at full width, so no wrap.
            frame.length_ok      = in_file_hdr ||
                                   (33'(tail_bytes) + 33'(BACK_ADD) == 33'(pkt_len));
            pkt_pos = '0;
        end else begin
            pkt_pos = pkt_pos + 25'd1;
        end
        return closes;
    endfunction

    // Offers one byte word after an optional gap and waits for it to be taken.
    // Valid stays high from one word to the next when there is no gap.
    task automatic push_byte(input logic [7:0] b);
        int unsigned gap;
        flvf_pkg::result_t frame;
        gap = tx_free ? 0 : idle_len();
        @(negedge aclk);
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid     <= 1'b1;
        s_data_byte <= b;
        do @(posedge aclk); while (!s_ready);
        if (frame_on_byte(b, frame)) begin
            frames_due.push_back(use_typed ? typed_frame : frame);
        end
    endtask

    // Expands a packet description into its bytes, big endian throughout.
    task automatic send_packet(input pkt_row_t p);
        int unsigned i;
        tx_free     = ($urandom_range(0, 3) == 0);
        use_typed   = p.typed;
        typed_frame = p.want;
        if (p.file_hdr) begin
            push_byte(FILE_MAGIC[23:16]);
            push_byte(FILE_MAGIC[15:8]);
            push_byte(FILE_MAGIC[7:0]);
            for (i = 3; i < HDR_BYTES; i++) begin
                push_byte(8'($urandom));
            end
        end else begin
            push_byte(p.kind);
            push_byte(p.size[23:16]);
            push_byte(p.size[15:8]);
            push_byte(p.size[7:0]);
            push_byte(p.stamp[23:16]);
            push_byte(p.stamp[15:8]);
            push_byte(p.stamp[7:0]);
            // Extended timestamp and stream id do not reach the result.
            for (i = 0; i < 4; i++) begin
                push_byte(8'($urandom));
            end
            for (i = 0; i < p.size; i++) begin
                push_byte(i == 0 ? p.flags : 8'($urandom));
            end
            push_byte(p.back_size[31:24]);
            push_byte(p.back_size[23:16]);
            push_byte(p.back_size[15:8]);
            push_byte(p.back_size[7:0]);
        end
        use_typed = 1'b0;
    endtask

    // Lowers valid and holds the sender off until every result word is in.
    task automatic drain_results();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
    endtask

    // Receiver: stalls of random length, with stretches where it never stalls.
    always @(negedge aclk) begin
        if (mode_left == 0) begin
            rx_free   <= ($urandom_range(0, 3) == 0);
            mode_left <= $urandom_range(50, 300);
        end else begin
            mode_left <= mode_left - 1;
        end
        if (stall_left != 0) begin
            m_ready    <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (!rx_free && $urandom_range(0, 2) == 0) begin
            m_ready    <= 1'b0;
            stall_left <= idle_len();
        end else begin
            m_ready <= 1'b1;
        end
    end

    // Every result word taken is checked against the oldest expected one.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            seen_frame = {m_is_file_header, m_tag_type, m_packet_length, m_time_stamp,
                          m_is_video, m_codec_id, m_frame_kind, m_length_ok};
            if (frames_due.size() == 0) begin
                if (bad_frames < 10) begin
                    $display("unexpected result word: len %0d type %h", m_packet_length,
                             m_tag_type);
                end
                bad_frames++;
            end else begin
                due_frame = frames_due.pop_front();
                if (seen_frame !== due_frame) begin
                    if (bad_frames < 10) begin
                        $display({"result mismatch (expected/actual): hdr %0d/%0d ",
                                  "type %h/%h len %0d/%0d stamp %h/%h video %0d/%0d ",
                                  "codec %h/%h frame %h/%h ok %0d/%0d"},
                                 due_frame.is_file_header, seen_frame.is_file_header,
                                 due_frame.tag_type, seen_frame.tag_type,
                                 due_frame.packet_length, seen_frame.packet_length,
                                 due_frame.time_stamp, seen_frame.time_stamp,
                                 due_frame.is_video, seen_frame.is_video,
                                 due_frame.codec_id, seen_frame.codec_id,
                                 due_frame.frame_kind, seen_frame.frame_kind,
                                 due_frame.length_ok, seen_frame.length_ok);
                    end
                    bad_frames++;
                end
            end
        end
    end

    // Watchdog: ends the run after too many cycles without any word moving.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        pkt_row_t    row;
        int unsigned pick;
        int unsigned pkt_no;
        int unsigned big_at;
        int unsigned stream_bytes;

        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Directed packets straight from the table.
        for (int unsigned r = 0; r < DIR_ROWS; r++) begin
            send_packet(DIR_TABLE[r]);
        end
        drain_results();

        // Random stream: mostly well-formed tags with random content, some file
        // headers, some tags with a wrong trailing size, and at least one tag long
        // enough to carry a nonzero middle byte of the data size.
        big_at       = $urandom_range(2, 12);
        pkt_no       = 0;
        stream_bytes = 0;
        while (stream_bytes < STREAM_BYTES) begin
            row  = '0;
            pick = $urandom_range(0, 99);
            if (pkt_no == big_at) begin
                row.kind      = TAG_VIDEO;
                row.size      = 24'h000105;
                row.stamp     = 24'($urandom);
                row.flags     = 8'($urandom);
                row.back_size = 32'(row.size) + 32'(TAG_EXTRA - BACK_ADD);
            end else if (pick < 10) begin
                row.file_hdr = 1'b1;
            end else begin
                case ($urandom_range(0, 3))
                    0:       row.kind = TAG_VIDEO;
                    1:       row.kind = TAG_AUDIO;
                    2:       row.kind = TAG_SCRIPT;
                    default: row.kind = 8'($urandom);
                endcase
                pick = $urandom_range(0, 99);
                if (pick < 85) begin
                    row.size = 24'($urandom_range(0, 24));
                end else if (pick < 95) begin
                    row.size = 24'($urandom_range(25, 120));
                end else begin
                    row.size = 24'($urandom_range(200, 700));
                end
                row.stamp     = 24'($urandom);
                row.flags     = 8'($urandom);
                row.back_size = 32'(row.size) + 32'(TAG_EXTRA - BACK_ADD);
                // About one tag in five carries a wrong trailing size.
                if ($urandom_range(0, 4) == 0) begin
                    case ($urandom_range(0, 3))
                        0:       row.back_size = $urandom;
                        1:       row.back_size[31:25] = 7'($urandom_range(1, 127));
                        2:       row.back_size = row.back_size + 32'd1;
                        default: row.back_size = row.back_size - 32'd1;
                    endcase
                end
            end

            if (pkt_no == DRAIN_AT) begin
                drain_results();
            end
            send_packet(row);
            stream_bytes += row.file_hdr ? HDR_BYTES : int'(row.size) + TAG_EXTRA;
            pkt_no++;
        end

        @(negedge aclk);
        s_valid <= 1'b0;
        while (frames_due.size() != 0) @(posedge aclk);
        // A byte that closes no packet can still be in flight; give it time.
        repeat (8) @(posedge aclk);

        if (bad_frames == 0 && frames_due.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
